[src/encoder_multiturn_unwrap_unit_assert.svh]
// Assertion macros for the encoder multiturn unwrap unit.
// Expects signals named clk and rst_n in the including module.
`ifndef ENCODER_MULTITURN_UNWRAP_UNIT_ASSERT_SVH
`define ENCODER_MULTITURN_UNWRAP_UNIT_ASSERT_SVH

// Same-cycle implication.
`define EMU_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (prop)) \
        else $error(msg);

// Next-cycle implication.
`define EMU_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[src/emu_pkg.sv]
// Shared widths, constants and register index codes of the encoder unwrap unit.
// No dependencies.
package emu_pkg;

    localparam int ANGLE_W    = 13;
    localparam int RATE_W     = 15;
    localparam int IO_W       = 16;
    localparam int CNT_W      = 32;
    localparam int TURN_COUNTS = 8192;

    localparam int AVERAGE_DEPTH_DEFAULT = 8;

    // Config port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [ANGLE_W-1:0] WRAP_THRESHOLD_RESET = 13'd4096;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_WRAP_THRESHOLD = 2'd0,
        CFG_ZERO_OFFSET    = 2'd1,
        CFG_FILTER_MODE    = 2'd2
    } cfg_index_t;

    // Degrees: total * 45 / 1024, toward zero
    localparam int DEG_SCALE  = 45;
    localparam int DEG_SHIFT  = 10;
    localparam int DEG_PROD_W = CNT_W + 6;

    // Averaged speed: avg * 7324 / 1000, toward zero
    localparam int AVG_W       = 15;                 // |avg| <= 16384
    localparam int SPEED_NUM   = 7324;
    localparam int SPEED_DEN   = 1000;
    localparam int PROD_W      = 27;                 // 16384 * 7324 < 2**27
    localparam int DEN_L       = 10;                 // clog2(1000)
    localparam int DEN_K       = PROD_W + DEN_L;
    localparam int DEN_MW      = PROD_W + 1;
    localparam longint DEN_M   = ((longint'(1) << DEN_K) + SPEED_DEN - 1) / SPEED_DEN;
    localparam int Q_W         = PROD_W + DEN_MW - DEN_K;

    localparam int SPEED_MAX     = 32767;
    localparam int SPEED_MIN_MAG = 32768;

endpackage

[src/encoder_multiturn_unwrap_unit.sv]
// Encoder multiturn unwrap unit: turn counting, totals, degrees, averaged speed.
// Depends on emu_pkg and encoder_multiturn_unwrap_unit_assert.svh.
//
//  channel   signals                                           direction
//  -------   -----------------------------------------------   ---------
//  input     in_valid/in_ready, angle_raw, reported_speed,      in
//            reported_current
//  output    out_valid/out_ready, step_rate, turn_count,        out
//            total_count, total_degrees, speed_out, current_out
//  config    cfg_wr_en, cfg_index, cfg_data                     in
//
// One transaction per cycle sustained while out_ready stays high. Five register stages
// (state update, total and window average, scale multiplies, degree shift and
// divide by 1000, saturation into the output register). Reset (async, active low)
// clears the valid flags and unwrap state and loads the register defaults.
// A stage holds only while the next one is full and stalled; in_ready drops once
// all five stages hold a transaction and out_ready is low.
`include "encoder_multiturn_unwrap_unit_assert.svh"

module encoder_multiturn_unwrap_unit #(
    parameter int AVERAGE_DEPTH = emu_pkg::AVERAGE_DEPTH_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,

    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [emu_pkg::ANGLE_W-1:0]           angle_raw,
    input  logic signed [emu_pkg::IO_W-1:0]       reported_speed,
    input  logic signed [emu_pkg::IO_W-1:0]       reported_current,

    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [emu_pkg::RATE_W-1:0]     step_rate,
    output logic signed [emu_pkg::CNT_W-1:0]      turn_count,
    output logic signed [emu_pkg::CNT_W-1:0]      total_count,
    output logic signed [emu_pkg::CNT_W-1:0]      total_degrees,
    output logic signed [emu_pkg::IO_W-1:0]       speed_out,
    output logic signed [emu_pkg::IO_W-1:0]       current_out,

    input  logic                                  cfg_wr_en,
    input  logic [emu_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [emu_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int ANGLE_W = emu_pkg::ANGLE_W;
    localparam int RATE_W  = emu_pkg::RATE_W;
    localparam int IO_W    = emu_pkg::IO_W;
    localparam int CNT_W   = emu_pkg::CNT_W;
    localparam int AVG_W   = emu_pkg::AVG_W;
    localparam int PROD_W  = emu_pkg::PROD_W;
    localparam int Q_W     = emu_pkg::Q_W;
    localparam int DEG_PROD_W = emu_pkg::DEG_PROD_W;

    // Window sizing and divide-by-depth reciprocal (exact for |sum| < 2**MAG_W)
    localparam int DEPTH_L = $clog2(AVERAGE_DEPTH);
    localparam int SLOT_W  = (AVERAGE_DEPTH > 1) ? DEPTH_L : 1;
    localparam int SUM_W   = RATE_W + DEPTH_L;
    localparam int MAG_W   = SUM_W;
    localparam int DIV_K   = MAG_W + DEPTH_L;
    localparam int DIV_MW  = MAG_W + 1;
    localparam longint DIV_M = ((longint'(1) << DIV_K) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
    localparam logic [DIV_MW-1:0] DIV_M_C = DIV_MW'(DIV_M);
    localparam logic [emu_pkg::DEN_MW-1:0] DEN_M_C = emu_pkg::DEN_MW'(emu_pkg::DEN_M);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(AVERAGE_DEPTH - 1);
    localparam logic signed [RATE_W-1:0] TURN_STEP = RATE_W'(emu_pkg::TURN_COUNTS);

    // ---------------- config registers ----------------
    logic [ANGLE_W-1:0] wrap_threshold_reg;
    logic [ANGLE_W-1:0] zero_offset_reg;
    logic               filter_mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_threshold_reg <= emu_pkg::WRAP_THRESHOLD_RESET;
            zero_offset_reg    <= '0;
            filter_mode_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            case (emu_pkg::cfg_index_t'(cfg_index))
                emu_pkg::CFG_WRAP_THRESHOLD: wrap_threshold_reg <= cfg_data[ANGLE_W-1:0];
                emu_pkg::CFG_ZERO_OFFSET:    zero_offset_reg    <= cfg_data[ANGLE_W-1:0];
                emu_pkg::CFG_FILTER_MODE:    filter_mode_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- stage enables ----------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4, en5, accept;

    assign en5    = !out_valid_reg || out_ready;
    assign en4    = !s4_valid_reg || en5;
    assign en3    = !s3_valid_reg || en4;
    assign en2    = !s2_valid_reg || en3;
    assign en1    = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign accept = in_valid && en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1) s1_valid_reg  <= in_valid;
            if (en2) s2_valid_reg  <= s1_valid_reg;
            if (en3) s3_valid_reg  <= s2_valid_reg;
            if (en4) s4_valid_reg  <= s3_valid_reg;
            if (en5) out_valid_reg <= s4_valid_reg;
        end
    end

    // ---------------- stage 1: unwrap and window update ----------------
    // The state registers double as stage-1 data: they are only rewritten on
    // an accept, and an accept always moves the previous item on to stage 2.
    logic [ANGLE_W-1:0]        prev_angle_reg;
    logic signed [CNT_W-1:0]   turns_reg, turns_next;
    logic signed [SUM_W-1:0]   sum_reg, sum_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic signed [RATE_W-1:0]  hist_reg [AVERAGE_DEPTH];

    logic signed [ANGLE_W:0]   diff, thr_s;
    logic signed [RATE_W-1:0]  diff_ext, rate_next, old_rate;
    logic                      wrap_dn, wrap_up;

    logic signed [RATE_W-1:0]  s1_rate_reg;
    logic signed [IO_W-1:0]    s1_speed_reg, s1_current_reg;

    always_comb
    begin
        diff     = $signed({1'b0, angle_raw}) - $signed({1'b0, prev_angle_reg});
        thr_s    = $signed({1'b0, wrap_threshold_reg});
        wrap_dn  = diff > thr_s;
        wrap_up  = diff < -thr_s;
        diff_ext = RATE_W'(diff);
        old_rate = hist_reg[slot_reg];
        if (wrap_dn)
        begin
            rate_next  = diff_ext - TURN_STEP;
            turns_next = turns_reg - CNT_W'(1);
        end
        else if (wrap_up)
        begin
            rate_next  = diff_ext + TURN_STEP;
            turns_next = turns_reg + CNT_W'(1);
        end
        else
        begin
            rate_next  = diff_ext;
            turns_next = turns_reg;
        end
        sum_next  = sum_reg - SUM_W'(old_rate) + SUM_W'(rate_next);
        slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_angle_reg <= '0;
            turns_reg      <= '0;
            sum_reg        <= '0;
            slot_reg       <= '0;
            for (int i = 0; i < AVERAGE_DEPTH; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            prev_angle_reg     <= angle_raw;
            turns_reg          <= turns_next;
            sum_reg            <= sum_next;
            slot_reg           <= slot_next;
            hist_reg[slot_reg] <= rate_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rate_reg    <= rate_next;
            s1_speed_reg   <= reported_speed;
            s1_current_reg <= reported_current;
        end
    end

    // ---------------- stage 2: total count, window average ----------------
    logic [MAG_W-1:0]          sum_mag;
    logic [MAG_W+DIV_MW-1:0]   avg_prod;
    logic signed [CNT_W-1:0]   total_next;

    logic signed [RATE_W-1:0]  s2_rate_reg;
    logic signed [CNT_W-1:0]   s2_turns_reg, s2_total_reg;
    logic [AVG_W-1:0]          s2_avg_reg;
    logic                      s2_neg_reg;
    logic signed [IO_W-1:0]    s2_speed_reg, s2_current_reg;

    always_comb
    begin
        // turns * 8192 + angle is a plain concatenation
        total_next = $signed({turns_reg[CNT_W-ANGLE_W-1:0], prev_angle_reg})
                   - $signed(CNT_W'(zero_offset_reg));
        sum_mag    = sum_reg[SUM_W-1] ? MAG_W'(-sum_reg) : MAG_W'(sum_reg);
        avg_prod   = {{DIV_MW{1'b0}}, sum_mag} * {{MAG_W{1'b0}}, DIV_M_C};
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            s2_rate_reg    <= s1_rate_reg;
            s2_turns_reg   <= turns_reg;
            s2_total_reg   <= total_next;
            s2_avg_reg     <= avg_prod[DIV_K +: AVG_W];
            s2_neg_reg     <= sum_reg[SUM_W-1];
            s2_speed_reg   <= s1_speed_reg;
            s2_current_reg <= s1_current_reg;
        end
    end

    // ---------------- stage 3: scale multiplies ----------------
    logic signed [DEG_PROD_W-1:0] s3_deg45_reg;
    logic [PROD_W-1:0]            s3_prod_reg;
    logic signed [RATE_W-1:0]     s3_rate_reg;
    logic signed [CNT_W-1:0]      s3_turns_reg, s3_total_reg;
    logic                         s3_neg_reg;
    logic signed [IO_W-1:0]       s3_speed_reg, s3_current_reg;

    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            s3_deg45_reg   <= DEG_PROD_W'(s2_total_reg)
                            * $signed(DEG_PROD_W'(emu_pkg::DEG_SCALE));
            s3_prod_reg    <= PROD_W'(s2_avg_reg) * PROD_W'(emu_pkg::SPEED_NUM);
            s3_rate_reg    <= s2_rate_reg;
            s3_turns_reg   <= s2_turns_reg;
            s3_total_reg   <= s2_total_reg;
            s3_neg_reg     <= s2_neg_reg;
            s3_speed_reg   <= s2_speed_reg;
            s3_current_reg <= s2_current_reg;
        end
    end

    // ---------------- stage 4: degrees shift, divide by 1000 ----------------
    logic signed [DEG_PROD_W-1:0]                deg_biased;
    logic [PROD_W+emu_pkg::DEN_MW-1:0]           q_prod;

    logic signed [CNT_W-1:0]   s4_deg_reg;
    logic [Q_W-1:0]            s4_q_reg;
    logic signed [RATE_W-1:0]  s4_rate_reg;
    logic signed [CNT_W-1:0]   s4_turns_reg, s4_total_reg;
    logic                      s4_neg_reg;
    logic signed [IO_W-1:0]    s4_speed_reg, s4_current_reg;

    always_comb
    begin
        // bias negatives so the arithmetic shift truncates toward zero
        deg_biased = s3_deg45_reg + (s3_deg45_reg[DEG_PROD_W-1]
                   ? DEG_PROD_W'((1 << emu_pkg::DEG_SHIFT) - 1) : DEG_PROD_W'(0));
        q_prod     = {{emu_pkg::DEN_MW{1'b0}}, s3_prod_reg} * {{PROD_W{1'b0}}, DEN_M_C};
    end

    always_ff @(posedge clk)
    begin
        if (en4 && s3_valid_reg)
        begin
            s4_deg_reg     <= CNT_W'(deg_biased >>> emu_pkg::DEG_SHIFT);
            s4_q_reg       <= q_prod[emu_pkg::DEN_K +: Q_W];
            s4_rate_reg    <= s3_rate_reg;
            s4_turns_reg   <= s3_turns_reg;
            s4_total_reg   <= s3_total_reg;
            s4_neg_reg     <= s3_neg_reg;
            s4_speed_reg   <= s3_speed_reg;
            s4_current_reg <= s3_current_reg;
        end
    end

    // ---------------- output register: saturation and mode select ----------------
    logic signed [IO_W-1:0]  avg_speed;
    logic signed [Q_W:0]     q_neg;

    logic signed [RATE_W-1:0]  out_rate_reg;
    logic signed [CNT_W-1:0]   out_turns_reg, out_total_reg, out_deg_reg;
    logic signed [IO_W-1:0]    out_speed_reg, out_current_reg;

    always_comb
    begin
        q_neg = -$signed({1'b0, s4_q_reg});
        if (s4_neg_reg)
        begin
            avg_speed = (s4_q_reg > Q_W'(emu_pkg::SPEED_MIN_MAG))
                      ? IO_W'(-emu_pkg::SPEED_MIN_MAG) : IO_W'(q_neg);
        end
        else
        begin
            avg_speed = (s4_q_reg > Q_W'(emu_pkg::SPEED_MAX))
                      ? IO_W'(emu_pkg::SPEED_MAX) : IO_W'(s4_q_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en5 && s4_valid_reg)
        begin
            out_rate_reg    <= s4_rate_reg;
            out_turns_reg   <= s4_turns_reg;
            out_total_reg   <= s4_total_reg;
            out_deg_reg     <= s4_deg_reg;
            out_speed_reg   <= filter_mode_reg ? avg_speed : s4_speed_reg;
            out_current_reg <= filter_mode_reg ? IO_W'(0) : s4_current_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_rate     = out_rate_reg;
    assign turn_count    = out_turns_reg;
    assign total_count   = out_total_reg;
    assign total_degrees = out_deg_reg;
    assign speed_out     = out_speed_reg;
    assign current_out   = out_current_reg;

    // ---------------- assertions ----------------
    `EMU_ASSERT_NOW(a_rate_range, s1_valid_reg,
        (s1_rate_reg <= 15'sd8191) && (s1_rate_reg >= -15'sd8191),
        "step rate out of unwrap range")
    `EMU_ASSERT_NEXT(a_turn_step, accept,
        (turns_reg == $past(turns_reg)) || (turns_reg == $past(turns_reg) + 32'sd1)
            || (turns_reg == $past(turns_reg) - 32'sd1),
        "turn count moved by more than one")
    `EMU_ASSERT_NOW(a_slot_range, 1'b1, slot_reg <= SLOT_LAST, "history slot beyond window")
    `EMU_ASSERT_NEXT(a_s4_hold, s4_valid_reg && out_valid_reg && !out_ready,
        s4_valid_reg && out_valid_reg, "pipeline dropped a transaction under stall")

endmodule
